@@ hdl/utpp_pkg.sv @@
// Package for the telemetry datagram parser: phase codes, error and kind
// codes, and the result item type. No dependencies.
package utpp_pkg;

  typedef enum logic [3:0] {
    PH_TYPE, PH_BLEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_VALUE, PH_SKIP,
    PH_REC_TYPE, PH_REC_LEN, PH_REC_DATA, PH_DRAIN
  } phase_e;

  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_SIG     = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_OVERRUN   = 3'd2;
  localparam logic [2:0] ERR_TOPIC_LEN = 3'd3;
  localparam logic [2:0] ERR_TOPIC_OVR = 3'd4;
  localparam logic [2:0] ERR_VALUE_LEN = 3'd5;
  localparam logic [2:0] ERR_RECORD    = 3'd6;
  localparam logic [2:0] ERR_LEN_FIELD = 3'd7;

  localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
  localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;

  localparam logic [7:0] REC_NUMBER = 8'h6E;
  localparam logic [7:0] REC_REPLY  = 8'h72;
  localparam logic [7:0] REC_SIG    = 8'h73;

  localparam logic [15:0] MAX_FIELD_RESET = 16'd4096;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [15:0] topic_length;
    logic [15:0] value_length;
    logic [31:0] packet_number;
    logic [31:0] reply_number;
    logic        has_signature;
    logic [15:0] signed_span;
    logic [2:0]  error_code;
    logic        last;
  } res_t;

endpackage

@@ hdl/utpp_if.sv @@
// Stream interfaces for the telemetry datagram parser: input bytes and
// result items. Depends on utpp_pkg.
interface utpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface utpp_res_if;
  logic          valid;
  logic          ready;
  utpp_pkg::res_t res;
  modport source (output valid, res, input ready);
  modport sink   (input valid, res, output ready);
endinterface

@@ hdl/utpp_parser.sv @@
// Parse state machine of the telemetry datagram parser: one byte per
// transfer, up to two result items. Depends on utpp_pkg.
module utpp_parser #(
  parameter int MAX_PACKET_BYTES  = 65536,
  parameter int MAX_LENGTH_GROUPS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     byte_i,
  input  logic           eop_i,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i,
  output logic [1:0]     n_res_o,
  output utpp_pkg::res_t res0_o,
  output utpp_pkg::res_t res1_o
);
  localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int GC_W  = ($clog2(MAX_LENGTH_GROUPS + 1) > 3) ?
                         $clog2(MAX_LENGTH_GROUPS + 1) : 3;
  localparam int HL_W  = GC_W + 1;
  localparam int CMP_W = (OFF_W > 29) ? OFF_W + 1 : 30;

  utpp_pkg::phase_e ph_q, ph_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [27:0] body_q, body_d, rem_q, rem_d, lacc_q, lacc_d;
  logic [HL_W-1:0] hl_q, hl_d;
  logic [GC_W-1:0] gc_q, gc_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [31:0] wacc_q, wacc_d;
  logic [3:0]  ptype_q, ptype_d, pflags_q, pflags_d;
  logic [15:0] tlen_q, tlen_d, vlen_q, vlen_d, span_q, span_d, maxf_q;
  logic [31:0] pnum_q, pnum_d, rnum_q, rnum_d;
  logic        sig_q, sig_d, zs_q, zs_d;
  logic [2:0]  err_q, err_d, e_fin;

  logic [27:0] grp_acc;
  logic [GC_W-1:0] grp_cnt;
  logic        grp_ovf, grp_done;
  logic [15:0] tl;
  logic [15:0] rstart;
  logic [CMP_W-1:0] body_end;
  logic        emit;
  utpp_pkg::res_t byte_res, sum_res;

  always_comb begin
    grp_acc  = {lacc_q[20:0], byte_i[6:0]};
    grp_cnt  = gc_q + GC_W'(1);
    grp_done = !byte_i[7];
    grp_ovf  = (lacc_q[27:21] != 7'd0) ||
               (!grp_done && (grp_cnt >= GC_W'(MAX_LENGTH_GROUPS)));
    tl       = {wacc_q[7:0], byte_i};
  end

  always_comb begin
    ph_d = ph_q; off_d = off_q; body_d = body_q; rem_d = rem_q; lacc_d = lacc_q;
    hl_d = hl_q; gc_d = gc_q; rtype_d = rtype_q; wacc_d = wacc_q;
    ptype_d = ptype_q; pflags_d = pflags_q; tlen_d = tlen_q; vlen_d = vlen_q;
    span_d = span_q; pnum_d = pnum_q; rnum_d = rnum_q; sig_d = sig_q;
    zs_d = zs_q; err_d = err_q;
    emit = 1'b0;
    byte_res = '0;
    byte_res.payload_byte = byte_i;
    rstart = '0;
    e_fin = '0;
    sum_res = '0;
    body_end = '0;

    if (off_q >= OFF_W'(MAX_PACKET_BYTES)) begin
      if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_OVERRUN;
      ph_d = utpp_pkg::PH_DRAIN;
    end else begin
      off_d = off_q + OFF_W'(1);
    end

    unique case (ph_d)
      utpp_pkg::PH_TYPE: begin
        ptype_d = byte_i[7:4];
        pflags_d = byte_i[3:0];
        lacc_d = '0; gc_d = '0;
        ph_d = utpp_pkg::PH_BLEN;
      end
      utpp_pkg::PH_BLEN: begin
        if (grp_ovf) begin
          if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_LEN_FIELD;
          ph_d = utpp_pkg::PH_DRAIN;
        end else begin
          lacc_d = grp_acc; gc_d = grp_cnt;
          if (grp_done) begin
            body_d = grp_acc;
            hl_d = HL_W'(grp_cnt) + HL_W'(1);
            if (ptype_q == utpp_pkg::TYPE_PUBLISH || ptype_q == utpp_pkg::TYPE_SUBSCRIBE)
              ph_d = utpp_pkg::PH_TLEN_HI;
            else if (grp_acc == '0) ph_d = utpp_pkg::PH_REC_TYPE;
            else begin
              rem_d = grp_acc; ph_d = utpp_pkg::PH_SKIP;
            end
          end
        end
      end
      utpp_pkg::PH_TLEN_HI: begin
        wacc_d = {24'd0, byte_i};
        ph_d = utpp_pkg::PH_TLEN_LO;
      end
      utpp_pkg::PH_TLEN_LO: begin
        if (tl > maxf_q) begin
          if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_TOPIC_LEN;
          ph_d = utpp_pkg::PH_DRAIN;
        end else if ({12'd0, tl} + 28'd2 > body_q) begin
          if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_TOPIC_OVR;
          ph_d = utpp_pkg::PH_DRAIN;
        end else begin
          lacc_d = body_q - 28'd2 - {12'd0, tl};
          if (tl == 16'd0) begin
            // Topic is empty, so the value field starts right away.
            if (lacc_d > {12'd0, maxf_q}) begin
              if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_VALUE_LEN;
              ph_d = utpp_pkg::PH_DRAIN;
            end else if (lacc_d == '0) ph_d = utpp_pkg::PH_REC_TYPE;
            else begin
              rem_d = lacc_d; zs_d = 1'b0;
              ph_d = (ptype_q == utpp_pkg::TYPE_PUBLISH) ?
                     utpp_pkg::PH_VALUE : utpp_pkg::PH_SKIP;
            end
          end else begin
            rem_d = {12'd0, tl}; zs_d = 1'b0; ph_d = utpp_pkg::PH_TOPIC;
          end
        end
      end
      utpp_pkg::PH_TOPIC: begin
        emit = 1'b1;
        byte_res.kind = utpp_pkg::KIND_TOPIC;
        if (byte_i == 8'd0) zs_d = 1'b1;
        else if (!zs_q) tlen_d = tlen_q + 16'd1;
        rem_d = rem_q - 28'd1;
        if (rem_d == '0) begin
          if (lacc_q > {12'd0, maxf_q}) begin
            if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_VALUE_LEN;
            ph_d = utpp_pkg::PH_DRAIN;
          end else if (lacc_q == '0) ph_d = utpp_pkg::PH_REC_TYPE;
          else begin
            rem_d = lacc_q; zs_d = 1'b0;
            ph_d = (ptype_q == utpp_pkg::TYPE_PUBLISH) ?
                   utpp_pkg::PH_VALUE : utpp_pkg::PH_SKIP;
          end
        end
      end
      utpp_pkg::PH_VALUE: begin
        emit = 1'b1;
        byte_res.kind = utpp_pkg::KIND_VALUE;
        if (byte_i == 8'd0) zs_d = 1'b1;
        else if (!zs_q) vlen_d = vlen_q + 16'd1;
        rem_d = rem_q - 28'd1;
        if (rem_d == '0) ph_d = utpp_pkg::PH_REC_TYPE;
      end
      utpp_pkg::PH_SKIP: begin
        rem_d = rem_q - 28'd1;
        if (rem_d == '0) ph_d = utpp_pkg::PH_REC_TYPE;
      end
      utpp_pkg::PH_REC_TYPE: begin
        rtype_d = byte_i;
        rstart = 16'(off_d - OFF_W'(1));
        lacc_d = '0; gc_d = '0; wacc_d = '0;
        if (byte_i == utpp_pkg::REC_SIG) begin
          sig_d = 1'b1; span_d = rstart;
        end
        ph_d = utpp_pkg::PH_REC_LEN;
      end
      utpp_pkg::PH_REC_LEN: begin
        if (grp_ovf) begin
          if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_LEN_FIELD;
          ph_d = utpp_pkg::PH_DRAIN;
        end else begin
          lacc_d = grp_acc; gc_d = grp_cnt;
          if (grp_done) begin
            if (grp_acc == '0) begin
              if (err_d == utpp_pkg::ERR_OK) err_d = utpp_pkg::ERR_RECORD;
              ph_d = utpp_pkg::PH_DRAIN;
            end else begin
              rem_d = grp_acc; gc_d = '0; ph_d = utpp_pkg::PH_REC_DATA;
            end
          end
        end
      end
      utpp_pkg::PH_REC_DATA: begin
        if ((rtype_q == utpp_pkg::REC_NUMBER || rtype_q == utpp_pkg::REC_REPLY) &&
            gc_q < GC_W'(4)) begin
          wacc_d = {wacc_q[23:0], byte_i};
          gc_d = gc_q + GC_W'(1);
        end
        if (rtype_q == utpp_pkg::REC_SIG) begin
          emit = 1'b1; byte_res.kind = utpp_pkg::KIND_SIG;
        end
        rem_d = rem_q - 28'd1;
        if (rem_d == '0) begin
          if (rtype_q == utpp_pkg::REC_NUMBER) pnum_d = wacc_d;
          else if (rtype_q == utpp_pkg::REC_REPLY) rnum_d = wacc_d;
          ph_d = utpp_pkg::PH_REC_TYPE;
        end
      end
      default: ;
    endcase

    if (eop_i) begin
      body_end = CMP_W'(hl_d) + CMP_W'(body_d);
      e_fin = err_d;
      if (off_d < OFF_W'(2)) e_fin = utpp_pkg::ERR_SHORT;
      else if (err_d == utpp_pkg::ERR_OK) begin
        priority case (ph_d)
          utpp_pkg::PH_BLEN: e_fin = utpp_pkg::ERR_OVERRUN;
          utpp_pkg::PH_TLEN_HI, utpp_pkg::PH_TLEN_LO, utpp_pkg::PH_TOPIC,
          utpp_pkg::PH_VALUE, utpp_pkg::PH_SKIP:
            e_fin = (CMP_W'(off_d) < body_end) ? utpp_pkg::ERR_OVERRUN
                                                : utpp_pkg::ERR_TOPIC_OVR;
          utpp_pkg::PH_REC_LEN, utpp_pkg::PH_REC_DATA: e_fin = utpp_pkg::ERR_RECORD;
          default: ;
        endcase
      end else if (err_d >= utpp_pkg::ERR_TOPIC_LEN && err_d <= utpp_pkg::ERR_VALUE_LEN &&
                   CMP_W'(off_d) < body_end) begin
        e_fin = utpp_pkg::ERR_OVERRUN;
      end
      sum_res.kind = utpp_pkg::KIND_SUMMARY;
      sum_res.packet_type = ptype_d;
      sum_res.packet_flags = pflags_d;
      sum_res.topic_length = tlen_d;
      sum_res.value_length = vlen_d;
      sum_res.packet_number = pnum_d;
      sum_res.reply_number = rnum_d;
      sum_res.has_signature = sig_d;
      sum_res.signed_span = span_d;
      sum_res.error_code = e_fin;
      sum_res.last = 1'b1;
      ph_d = utpp_pkg::PH_TYPE; off_d = '0; body_d = '0; rem_d = '0; lacc_d = '0;
      hl_d = '0; gc_d = '0; rtype_d = '0; wacc_d = '0; ptype_d = '0; pflags_d = '0;
      tlen_d = '0; vlen_d = '0; span_d = '0; pnum_d = '0; rnum_d = '0; sig_d = 1'b0;
      zs_d = 1'b0; err_d = '0;
    end
  end

  always_comb begin
    n_res_o = acc_i ? (2'(emit) + 2'(eop_i)) : 2'd0;
    res0_o = emit ? byte_res : sum_res;
    res1_o = sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= utpp_pkg::PH_TYPE; off_q <= '0; body_q <= '0; rem_q <= '0;
      lacc_q <= '0; hl_q <= '0; gc_q <= '0; rtype_q <= '0; wacc_q <= '0;
      ptype_q <= '0; pflags_q <= '0; tlen_q <= '0; vlen_q <= '0; span_q <= '0;
      pnum_q <= '0; rnum_q <= '0; sig_q <= 1'b0; zs_q <= 1'b0; err_q <= '0;
      maxf_q <= utpp_pkg::MAX_FIELD_RESET;
    end else begin
      if (cfg_we_i) maxf_q <= cfg_data_i;
      if (acc_i) begin
        ph_q <= ph_d; off_q <= off_d; body_q <= body_d; rem_q <= rem_d;
        lacc_q <= lacc_d; hl_q <= hl_d; gc_q <= gc_d; rtype_q <= rtype_d;
        wacc_q <= wacc_d; ptype_q <= ptype_d; pflags_q <= pflags_d;
        tlen_q <= tlen_d; vlen_q <= vlen_d; span_q <= span_d; pnum_q <= pnum_d;
        rnum_q <= rnum_d; sig_q <= sig_d; zs_q <= zs_d; err_q <= err_d;
      end
    end
  end
endmodule

@@ hdl/utpp_res_buf.sv @@
// Two-entry result buffer: takes up to two items per cycle, releases one.
// Depends on utpp_pkg.
module utpp_res_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_n_i,
  input  utpp_pkg::res_t push0_i,
  input  utpp_pkg::res_t push1_i,
  output logic           has_room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output utpp_pkg::res_t res_o
);
  utpp_pkg::res_t slot_q [2];
  utpp_pkg::res_t slot_d [2];
  logic [1:0] cnt_q, cnt_d, left;
  logic       pop;

  always_comb begin
    pop = valid_o && ready_i;
    left = cnt_q - 2'(pop);
    has_room_o = (left == 2'd0);
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    if (push_n_i != 2'd0) begin
      if (left == 2'd0) begin
        slot_d[0] = push0_i;
        slot_d[1] = push1_i;
      end else begin
        slot_d[1] = push0_i;
      end
    end
    cnt_d = left + push_n_i;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign res_o = slot_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("result buffer count out of range");
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd2) |-> (left == 2'd0))
    else $error("two results pushed into an occupied buffer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(res_o))
    else $error("stalled head result changed");
endmodule

@@ hdl/udp_telemetry_packet_parser_unit.sv @@
// Top level of the telemetry datagram parser: parse state machine and result
// buffer. Depends on utpp_pkg, utpp_if, utpp_parser and utpp_res_buf.
//
//  Channel  Direction  Transfer carries
//  in_i     sink       data_byte, end_of_packet
//  out_o    source     res (kind, payload_byte, summary fields, last)
//  cfg      write      cfg_we_i, cfg_data_i (max_field_len)
//
// Each byte is parsed in the cycle of its transfer; the parse state registers
// hold the result of that single pass, and its results enter a two-entry buffer.
// A new byte is taken every cycle while out_o is ready and results drain at one
// per cycle; a byte that yields both a forwarded byte and the summary holds
// in_i.ready low until the single output port of the buffer releases the second.
// Reset is asynchronous and active low; it empties the buffer and clears the
// parser but sets max_field_len to its reset value. A stall on out_o holds the
// buffer and drops in_i.ready once it cannot take two more results.
module udp_telemetry_packet_parser_unit #(
  parameter int MAX_PACKET_BYTES  = 65536,
  parameter int MAX_LENGTH_GROUPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utpp_byte_if.sink   in_i,
  utpp_res_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);
  logic           acc;
  logic           room;
  logic [1:0]     n_res;
  utpp_pkg::res_t res0, res1;

  // The buffer must be able to take the worst case of two results.
  assign in_i.ready = room;
  assign acc = in_i.valid && room;

  utpp_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .MAX_LENGTH_GROUPS(MAX_LENGTH_GROUPS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .byte_i    (in_i.data_byte),
    .eop_i     (in_i.end_of_packet),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .n_res_o   (n_res),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  utpp_res_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_n_i  (n_res),
    .push0_i   (res0),
    .push1_i   (res1),
    .has_room_o(room),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_o     (out_o.res)
  );

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.res.last == (out_o.res.kind == utpp_pkg::KIND_SUMMARY)))
    else $error("last flag does not match summary kind");
  a_eop_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.end_of_packet) |-> (n_res != 2'd0))
    else $error("end of datagram produced no summary");
  a_no_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> (n_res == 2'd0))
    else $error("result produced without a transfer");
endmodule

@@ sim/tb_utpp_checker.sv @@
// Checker for the telemetry datagram parser: watches the byte and result
// channels, predicts results and compares them. Depends on utpp_pkg, utpp_if.
module tb_utpp_checker (
  input logic      clk_i,
  input logic      rst_ni,
  utpp_byte_if     in_mon,
  utpp_res_if      out_mon,
  input logic      cfg_we_i,
  input logic [15:0] cfg_data_i,
  output int       fail_count,
  output int       pending_count,
  output int       summary_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT_MAX = 65536;
  localparam int GROUPS_MAX = 4;

  utpp_pkg::res_t expected_q[$];

  logic [15:0] field_limit;
  utpp_pkg::phase_e phase;
  int unsigned offset, body_len, hdr_len, remaining, len_acc, grp_cnt;
  int unsigned rec_type, rec_start, word_acc;
  logic [3:0]  s_type, s_flags;
  logic [15:0] s_tlen, s_vlen, s_span;
  logic [31:0] s_num, s_reply;
  logic        s_sig, zero_hit;
  logic [2:0]  err_latch;

  function automatic void clear_datagram();
    phase = utpp_pkg::PH_TYPE;
    offset = 0; body_len = 0; hdr_len = 0; remaining = 0; len_acc = 0;
    grp_cnt = 0; rec_type = 0; rec_start = 0; word_acc = 0;
    s_type = 0; s_flags = 0; s_tlen = 0; s_vlen = 0; s_span = 0;
    s_num = 0; s_reply = 0; s_sig = 0; zero_hit = 0; err_latch = utpp_pkg::ERR_OK;
  endfunction

  function automatic void latch_error(logic [2:0] e);
    if (err_latch == utpp_pkg::ERR_OK) err_latch = e;
    phase = utpp_pkg::PH_DRAIN;
  endfunction

  // Returns 1 when the length is done, 0 for more groups, -1 on overflow.
  function automatic int add_group(logic [7:0] b);
    if ((len_acc >> 21) != 0) return -1;
    len_acc = ((len_acc << 7) | (b & 8'h7F)) & 32'h0FFF_FFFF;
    grp_cnt++;
    if (!b[7]) return 1;
    if (grp_cnt >= GROUPS_MAX) return -1;
    return 0;
  endfunction

  function automatic void topic_done();
    if (len_acc > field_limit) begin
      latch_error(utpp_pkg::ERR_VALUE_LEN);
      return;
    end
    if (len_acc == 0) begin
      phase = utpp_pkg::PH_REC_TYPE;
      return;
    end
    remaining = len_acc;
    zero_hit = 0;
    phase = (s_type == utpp_pkg::TYPE_PUBLISH) ? utpp_pkg::PH_VALUE : utpp_pkg::PH_SKIP;
  endfunction

  function automatic void push_byte(logic [1:0] k, logic [7:0] b);
    utpp_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.payload_byte = b;
    expected_q.push_back(r);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eop);
    int r;
    int unsigned tl, body_end;
    logic [2:0] e;
    utpp_pkg::res_t s;
    if (offset >= PKT_MAX) latch_error(utpp_pkg::ERR_OVERRUN);
    else offset++;
    case (phase)
      utpp_pkg::PH_TYPE: begin
        s_type = b[7:4]; s_flags = b[3:0];
        len_acc = 0; grp_cnt = 0; phase = utpp_pkg::PH_BLEN;
      end
      utpp_pkg::PH_BLEN: begin
        r = add_group(b);
        if (r < 0) latch_error(utpp_pkg::ERR_LEN_FIELD);
        else if (r > 0) begin
          body_len = len_acc;
          hdr_len = 1 + grp_cnt;
          if (s_type == utpp_pkg::TYPE_PUBLISH || s_type == utpp_pkg::TYPE_SUBSCRIBE)
            phase = utpp_pkg::PH_TLEN_HI;
          else if (body_len == 0) phase = utpp_pkg::PH_REC_TYPE;
          else begin
            remaining = body_len; phase = utpp_pkg::PH_SKIP;
          end
        end
      end
      utpp_pkg::PH_TLEN_HI: begin
        word_acc = b; phase = utpp_pkg::PH_TLEN_LO;
      end
      utpp_pkg::PH_TLEN_LO: begin
        tl = ((word_acc & 8'hFF) << 8) | b;
        if (tl > field_limit) latch_error(utpp_pkg::ERR_TOPIC_LEN);
        else if (2 + tl > body_len) latch_error(utpp_pkg::ERR_TOPIC_OVR);
        else begin
          len_acc = body_len - 2 - tl;
          if (tl == 0) topic_done();
          else begin
            remaining = tl; zero_hit = 0; phase = utpp_pkg::PH_TOPIC;
          end
        end
      end
      utpp_pkg::PH_TOPIC: begin
        push_byte(utpp_pkg::KIND_TOPIC, b);
        if (b == 0) zero_hit = 1;
        else if (!zero_hit) s_tlen++;
        remaining--;
        if (remaining == 0) topic_done();
      end
      utpp_pkg::PH_VALUE: begin
        push_byte(utpp_pkg::KIND_VALUE, b);
        if (b == 0) zero_hit = 1;
        else if (!zero_hit) s_vlen++;
        remaining--;
        if (remaining == 0) phase = utpp_pkg::PH_REC_TYPE;
      end
      utpp_pkg::PH_SKIP: begin
        remaining--;
        if (remaining == 0) phase = utpp_pkg::PH_REC_TYPE;
      end
      utpp_pkg::PH_REC_TYPE: begin
        rec_type = b;
        rec_start = offset - 1;
        len_acc = 0; grp_cnt = 0; word_acc = 0;
        if (b == utpp_pkg::REC_SIG) begin
          s_sig = 1; s_span = rec_start[15:0];
        end
        phase = utpp_pkg::PH_REC_LEN;
      end
      utpp_pkg::PH_REC_LEN: begin
        r = add_group(b);
        if (r < 0) latch_error(utpp_pkg::ERR_LEN_FIELD);
        else if (r > 0) begin
          if (len_acc == 0) latch_error(utpp_pkg::ERR_RECORD);
          else begin
            remaining = len_acc; grp_cnt = 0; phase = utpp_pkg::PH_REC_DATA;
          end
        end
      end
      utpp_pkg::PH_REC_DATA: begin
        if ((rec_type == utpp_pkg::REC_NUMBER || rec_type == utpp_pkg::REC_REPLY) &&
            grp_cnt < 4) begin
          word_acc = (word_acc << 8) | b;
          grp_cnt++;
        end
        if (rec_type == utpp_pkg::REC_SIG) push_byte(utpp_pkg::KIND_SIG, b);
        remaining--;
        if (remaining == 0) begin
          if (rec_type == utpp_pkg::REC_NUMBER) s_num = word_acc;
          else if (rec_type == utpp_pkg::REC_REPLY) s_reply = word_acc;
          phase = utpp_pkg::PH_REC_TYPE;
        end
      end
      default: ;
    endcase
    if (eop) begin
      e = err_latch;
      body_end = hdr_len + body_len;
      if (offset < 2) e = utpp_pkg::ERR_SHORT;
      else if (e == utpp_pkg::ERR_OK) begin
        case (phase)
          utpp_pkg::PH_BLEN: e = utpp_pkg::ERR_OVERRUN;
          utpp_pkg::PH_TLEN_HI, utpp_pkg::PH_TLEN_LO, utpp_pkg::PH_TOPIC,
          utpp_pkg::PH_VALUE, utpp_pkg::PH_SKIP:
            e = (offset < body_end) ? utpp_pkg::ERR_OVERRUN : utpp_pkg::ERR_TOPIC_OVR;
          utpp_pkg::PH_REC_LEN, utpp_pkg::PH_REC_DATA: e = utpp_pkg::ERR_RECORD;
          default: ;
        endcase
      end else if (e >= utpp_pkg::ERR_TOPIC_LEN && e <= utpp_pkg::ERR_VALUE_LEN &&
                   offset < body_end)
        e = utpp_pkg::ERR_OVERRUN;
      s = '0;
      s.kind = utpp_pkg::KIND_SUMMARY;
      s.packet_type = s_type; s.packet_flags = s_flags;
      s.topic_length = s_tlen; s.value_length = s_vlen;
      s.packet_number = s_num; s.reply_number = s_reply;
      s.has_signature = s_sig; s.signed_span = s_span;
      s.error_code = e; s.last = 1'b1;
      expected_q.push_back(s);
      clear_datagram();
    end
  endfunction

  function automatic void compare_result(utpp_pkg::res_t a);
    utpp_pkg::res_t x;
    if (expected_q.size() == 0) begin
      $error("unexpected result %p", a);
      fail_count++;
      return;
    end
    x = expected_q.pop_front();
    if (a.kind != x.kind) begin
      $error("kind exp %0d got %0d", x.kind, a.kind); fail_count++;
    end
    if (a.payload_byte != x.payload_byte) begin
      $error("payload_byte exp %0h got %0h", x.payload_byte, a.payload_byte); fail_count++;
    end
    if (a.packet_type != x.packet_type) begin
      $error("packet_type exp %0d got %0d", x.packet_type, a.packet_type); fail_count++;
    end
    if (a.packet_flags != x.packet_flags) begin
      $error("packet_flags exp %0d got %0d", x.packet_flags, a.packet_flags); fail_count++;
    end
    if (a.topic_length != x.topic_length) begin
      $error("topic_length exp %0d got %0d", x.topic_length, a.topic_length); fail_count++;
    end
    if (a.value_length != x.value_length) begin
      $error("value_length exp %0d got %0d", x.value_length, a.value_length); fail_count++;
    end
    if (a.packet_number != x.packet_number) begin
      $error("packet_number exp %0h got %0h", x.packet_number, a.packet_number); fail_count++;
    end
    if (a.reply_number != x.reply_number) begin
      $error("reply_number exp %0h got %0h", x.reply_number, a.reply_number); fail_count++;
    end
    if (a.has_signature != x.has_signature) begin
      $error("has_signature exp %0d got %0d", x.has_signature, a.has_signature); fail_count++;
    end
    if (a.signed_span != x.signed_span) begin
      $error("signed_span exp %0d got %0d", x.signed_span, a.signed_span); fail_count++;
    end
    if (a.error_code != x.error_code) begin
      $error("error_code exp %0d got %0d", x.error_code, a.error_code); fail_count++;
    end
    if (a.last != x.last) begin
      $error("last exp %0d got %0d", x.last, a.last); fail_count++;
    end
    if (a.kind == utpp_pkg::KIND_SUMMARY) summary_count++;
  endfunction

  initial begin
    fail_count = 0;
    summary_count = 0;
    field_limit = utpp_pkg::MAX_FIELD_RESET;
    clear_datagram();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) compare_result(out_mon.res);
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data_byte, in_mon.end_of_packet);
      if (cfg_we_i) field_limit = cfg_data_i;
    end
    pending_count = expected_q.size();
  end
endmodule

@@ sim/tb_udp_telemetry_packet_parser_unit.sv @@
// Testbench top for the telemetry datagram parser: clock, reset, datagram
// stimulus and the verdict. Depends on utpp_pkg, utpp_if, tb_utpp_checker, udp_telemetry_packet_parser_unit.
module tb_udp_telemetry_packet_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;
  int          fail_count, pending_count, summary_count;
  int          bytes_sent;
  // While set, neither side inserts idle cycles.
  bit          no_gaps;
  // Datagram under construction; sent as a whole, one transfer per byte.
  logic [7:0]  dgram[$];

  utpp_byte_if in_if ();
  utpp_res_if  out_if ();

  udp_telemetry_packet_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  tb_utpp_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .summary_count (summary_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The result side stalls at random about 19 times in 100 unless the quiet stretch is on.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= no_gaps || ($urandom_range(99) >= 19);
    end
  end

  // Sends every byte of the datagram; valid stays high across back-to-back
  // transfers and drops only for a random idle cycle or at the end.
  task automatic send_datagram();
    for (int i = 0; i < dgram.size(); i++) begin
      if (!no_gaps && $urandom_range(99) < 19) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.data_byte <= dgram[i];
      in_if.end_of_packet <= (i == dgram.size() - 1);
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      bytes_sent++;
    end
    in_if.valid <= 1'b0;
    dgram.delete();
  endtask

  // Appends a length in 7-bit groups, most significant group first.
  task automatic put_length(int unsigned n);
    int g;
    g = 1;
    while (g < 4 && (n >> (7 * g)) != 0) g++;
    for (int k = g - 1; k >= 0; k--)
      dgram.push_back({(k != 0), 7'((n >> (7 * k)) & 7'h7F)});
  endtask

  task automatic put_record(logic [7:0] rtype, int unsigned len);
    dgram.push_back(rtype);
    put_length(len);
    for (int k = 0; k < len; k++) dgram.push_back(8'($urandom));
  endtask

  // Datagram of the given packet type with random topic and value, some with zero bytes
  // inside, followed by nrec tagged records.
  task automatic build_wellformed(logic [3:0] ptype, int unsigned tlen,
                                  int unsigned vlen, int nrec);
    logic [7:0] b;
    logic [7:0] tags[4];
    tags = '{utpp_pkg::REC_NUMBER, utpp_pkg::REC_REPLY, utpp_pkg::REC_SIG, 8'h41};
    dgram.push_back({ptype, 4'($urandom)});
    put_length(2 + tlen + vlen);
    dgram.push_back(8'(tlen >> 8));
    dgram.push_back(8'(tlen));
    for (int k = 0; k < tlen + vlen; k++) begin
      b = 8'($urandom);
      if ($urandom_range(15) == 0) b = 8'h00;
      dgram.push_back(b);
    end
    for (int k = 0; k < nrec; k++)
      put_record(tags[$urandom_range(3)], $urandom_range(1, 6));
  endtask

  task automatic write_limit(logic [15:0] v);
    // Wait until the block has drained every expected result.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned tl;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_packet = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    bytes_sent = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed datagrams: one byte alone, truncated header, overlong length,
    // zero-length record, short reply record, topic overrunning the body, cut-off body.
    dgram = '{8'hFF};                                   send_datagram();
    dgram = '{8'h30, 8'h85};                            send_datagram();
    dgram = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF};       send_datagram();
    dgram = '{8'h10, 8'h00, utpp_pkg::REC_NUMBER, 8'h00}; send_datagram();
    dgram = '{8'h1F, 8'h00, utpp_pkg::REC_REPLY, 8'h02, 8'hAB, 8'hCD}; send_datagram();
    dgram = '{8'h30, 8'h02, 8'h00, 8'h05};              send_datagram();
    dgram = '{8'h30, 8'h03, 8'h00};                     send_datagram();
    // Full publish with a long number record, signature and unknown record.
    dgram = '{8'h35, 8'h05, 8'h00, 8'h02, 8'h61, 8'h00, 8'h7F,
              utpp_pkg::REC_NUMBER, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
              utpp_pkg::REC_SIG, 8'h02, 8'h80, 8'h01, 8'h41, 8'h01, 8'h00};
    send_datagram();
    build_wellformed(utpp_pkg::TYPE_SUBSCRIBE, 3, 2, 1); send_datagram();
    // Topic length above the limit, then value length above the limit.
    write_limit(16'd0);
    dgram = '{8'h30, 8'h03, 8'h00, 8'h01, 8'h55};       send_datagram();
    dgram = '{8'h30, 8'h03, 8'h00, 8'h00, 8'h55};       send_datagram();
    write_limit(16'hFFFF);
    build_wellformed(utpp_pkg::TYPE_PUBLISH, 300, 200, 2); send_datagram();
    write_limit(utpp_pkg::MAX_FIELD_RESET);

    // Random part: mostly well-formed datagrams in several limit settings,
    // the rest noise and truncated datagrams.
    for (int p = 0; p < 4; p++) begin
      no_gaps = (p == 1);
      if (p == 2) write_limit(16'd3);
      if (p == 3) write_limit(16'($urandom_range(1, 40)));
      for (int d = 0; d < 12; d++) begin
        tl = $urandom_range(0, 12);
        case ($urandom_range(9))
          0: for (int k = 0; k <= $urandom_range(8); k++) dgram.push_back(8'($urandom));
          1: begin
            build_wellformed(utpp_pkg::TYPE_PUBLISH, tl, $urandom_range(0, 10), 2);
            dgram = dgram[0:$urandom_range(0, dgram.size() - 1)];
          end
          2: build_wellformed(4'($urandom), tl, $urandom_range(0, 6),
                              $urandom_range(0, 3));
          3, 4: build_wellformed(utpp_pkg::TYPE_SUBSCRIBE, tl, $urandom_range(0, 6),
                                 $urandom_range(0, 3));
          default: build_wellformed(utpp_pkg::TYPE_PUBLISH, tl, $urandom_range(0, 10),
                                    $urandom_range(0, 3));
        endcase
        send_datagram();
      end
    end
    write_limit(utpp_pkg::MAX_FIELD_RESET);
    while (bytes_sent < 1450) begin
      build_wellformed(($urandom_range(3) == 0) ? utpp_pkg::TYPE_SUBSCRIBE
                                                : utpp_pkg::TYPE_PUBLISH,
                       $urandom_range(0, 12), $urandom_range(0, 10),
                       $urandom_range(0, 3));
      send_datagram();
    end

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes; %0d datagram summaries checked.", bytes_sent,
             summary_count);
    if (fail_count == 0)
      $display("** udp_telemetry_packet_parser_unit: PASSED **");
    else
      $display("** udp_telemetry_packet_parser_unit: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** udp_telemetry_packet_parser_unit: FAILED **");
    $finish;
  end
endmodule
